FILE: src/srpg_pkg.sv
// Package for the stepper ramp pulse generator: beat types, register indexes,
// mode codes and the fixed widths of the serial multiply/divide path.
// No dependencies.
`default_nettype none

package srpg_pkg;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_W    = 16;
  localparam int PROD_W    = 2 * CFG_W;
  localparam int MUL_STEPS = CFG_W;
  localparam int DIV_STEPS = PROD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEADY_DELAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEPS   = 2'd2;

  localparam logic [CFG_W-1:0] START_DELAY_RST  = 16'd1000;
  localparam logic [CFG_W-1:0] STEADY_DELAY_RST = 16'd100;
  localparam logic [CFG_W-1:0] RAMP_STEPS_RST   = 16'd0;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [STEP_W-1:0] step_count;
    logic              direction;
  } srpg_in_t;

  typedef struct packed {
    logic pulse;
    logic dir_line;
    logic driver_enable;
    logic busy_res;
    logic done_res;
  } srpg_out_t;

  typedef struct packed {
    logic             start;
    logic [CFG_W-1:0] mult;
    logic [CFG_W-1:0] mcand;
    logic [CFG_W-1:0] divisor;
  } srpg_md_req_t;

  typedef struct packed {
    logic             done;
    logic [CFG_W-1:0] quot;
  } srpg_md_rsp_t;

endpackage

`default_nettype wire

FILE: src/srpg_muldiv.sv
// Bit-serial unsigned multiply then divide: quot = (mult * mcand) / divisor.
// Shift-add multiply one bit per cycle, then restoring division one bit per cycle.
// Depends on srpg_pkg.
`default_nettype none

module srpg_muldiv (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire srpg_pkg::srpg_md_req_t req_i,
  output srpg_pkg::srpg_md_rsp_t     rsp_o
);
  import srpg_pkg::*;

  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_MUL  = 3'b010,
    MD_DIV  = 3'b100
  } md_state_e;

  md_state_e        state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [CFG_W-1:0] hi_q, hi_d;
  logic [CFG_W-1:0] lo_q, lo_d;
  logic [CFG_W-1:0] rem_q, rem_d;
  logic [CFG_W-1:0] mcand_q, mcand_d;
  logic [CFG_W-1:0] div_q, div_d;
  logic [CFG_W-1:0] quot_q, quot_d;

  logic [CFG_W:0]    mul_sum;
  logic [CFG_W:0]    div_shift;
  logic              div_ge;
  logic [CFG_W:0]    div_sub;
  logic [PROD_W-1:0] qp_next;

  always_comb begin
    mul_sum   = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);
    div_shift = {rem_q, hi_q[CFG_W-1]};
    div_ge    = div_shift >= {1'b0, div_q};
    div_sub   = div_shift - {1'b0, div_q};
    qp_next   = {hi_q[CFG_W-2:0], lo_q, div_ge};
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    hi_d    = hi_q;
    lo_d    = lo_q;
    rem_d   = rem_q;
    mcand_d = mcand_q;
    div_d   = div_q;
    quot_d  = quot_q;
    unique case (state_q)
      MD_IDLE: begin
        if (req_i.start) begin
          hi_d    = '0;
          lo_d    = req_i.mult;
          mcand_d = req_i.mcand;
          div_d   = req_i.divisor;
          cnt_d   = '0;
          state_d = MD_MUL;
        end
      end
      MD_MUL: begin
        hi_d  = mul_sum[CFG_W:1];
        lo_d  = {mul_sum[0], lo_q[CFG_W-1:1]};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
          cnt_d   = '0;
          rem_d   = '0;
          state_d = MD_DIV;
        end
      end
      MD_DIV: begin
        rem_d = div_ge ? div_sub[CFG_W-1:0] : div_shift[CFG_W-1:0];
        hi_d  = qp_next[PROD_W-1:CFG_W];
        lo_d  = qp_next[CFG_W-1:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          done_d  = 1'b1;
          quot_d  = qp_next[CFG_W-1:0];
          state_d = MD_IDLE;
        end
      end
      default: begin
        state_d = MD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q    <= hi_d;
    lo_q    <= lo_d;
    rem_q   <= rem_d;
    mcand_q <= mcand_d;
    div_q   <= div_d;
    quot_q  <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

`default_nettype wire

FILE: src/stepper_ramp_pulse_generator_core.sv
// Top level of the one-axis stepper pulse generator with trapezoidal ramp.
// Depends on srpg_pkg and srpg_muldiv.
//
// Usage: the input channel carries start beats (mode 0: step count, direction)
// and tick beats (mode 1: one microsecond each). Every input beat yields one
// output beat with the pulse, direction, enable, busy and done levels after it.
// The config port (valid/ready, always ready) writes start_delay, steady_delay
// and ramp_steps by index; write it only while the block is idle.
// Flow: an accepted beat moves the block to ST_OUT, where its result is loaded
// into the output register once that register is empty or its beat is taken.
// A tick that ends a step inside a ramp recomputes the half period in the
// serial multiply/divide unit in ST_CALC, a multiply and then a division,
// before its result is loaded in ST_OUT like that of any other beat.
// One beat is worked on at a time; in_stall_o is high from acceptance until the
// result is loaded into the output register.
// A stalled receiver holds the output beat; the next input beat may be taken
// meanwhile, but its result waits until the held beat is taken.
// Reset clears the move state and output valid and restores register defaults.
`default_nettype none

module stepper_ramp_pulse_generator_core #(
  parameter int DELAY_BITS = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire srpg_pkg::srpg_in_t                   in_data_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output srpg_pkg::srpg_out_t                       out_data_o,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [srpg_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [srpg_pkg::CFG_W-1:0]           cfg_data_i
);
  import srpg_pkg::*;

  localparam int EXT_W = (DELAY_BITS > CFG_W) ? DELAY_BITS : CFG_W;
  localparam logic [DELAY_BITS-1:0] DMAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_OUT  = 3'b100
  } srpg_state_e;

  function automatic logic [DELAY_BITS-1:0] clamp_delay(input logic [CFG_W-1:0] v);
    logic [EXT_W-1:0]      ve;
    logic [EXT_W-1:0]      me;
    logic [DELAY_BITS-1:0] res;
    ve = EXT_W'(v);
    me = EXT_W'(DMAX);
    if (v == '0) begin
      res = DELAY_BITS'(1);
    end else if (ve > me) begin
      res = DMAX;
    end else begin
      res = DELAY_BITS'(v);
    end
    return res;
  endfunction

  srpg_state_e           state_q, state_d;
  logic [CFG_W-1:0]      start_delay_q, start_delay_d;
  logic [CFG_W-1:0]      steady_delay_q, steady_delay_d;
  logic [CFG_W-1:0]      ramp_steps_q, ramp_steps_d;
  logic [STEP_W-1:0]     step_idx_q, step_idx_d;
  logic [STEP_W-1:0]     total_q, total_d;
  logic [CFG_W-1:0]      ramp_q, ramp_d;
  logic [DELAY_BITS-1:0] cur_delay_q, cur_delay_d;
  logic [DELAY_BITS-1:0] half_timer_q, half_timer_d;
  logic                  phase_q, phase_d;
  logic                  moving_q, moving_d;
  logic                  dir_q, dir_d;
  logic                  done_q, done_d;
  logic [CFG_W-1:0]      base_q, base_d;
  logic                  neg_q, neg_d;
  logic                  out_valid_q, out_valid_d;
  srpg_out_t             out_q, out_d;

  srpg_md_req_t md_req;
  srpg_md_rsp_t md_rsp;

  logic [STEP_W-1:0]     step_next;
  logic [STEP_W-1:0]     half_n;
  logic [CFG_W-1:0]      ramp_new;
  logic [DELAY_BITS-1:0] start_cd;
  logic [DELAY_BITS-1:0] ht_dec;
  logic                  accel;
  logic                  decel;
  logic [CFG_W:0]        decel_m;
  logic [CFG_W-1:0]      diff_mag;
  logic                  st_gt_sd;
  logic [CFG_W:0]        calc_sum;
  logic [DELAY_BITS-1:0] calc_cd;
  logic                  fin;
  logic [DELAY_BITS-1:0] fin_delay;

  srpg_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  // config writes
  always_comb begin
    start_delay_d  = start_delay_q;
    steady_delay_d = steady_delay_q;
    ramp_steps_d   = ramp_steps_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_START_DELAY:  start_delay_d  = cfg_data_i;
        CFG_STEADY_DELAY: steady_delay_d = cfg_data_i;
        CFG_RAMP_STEPS:   ramp_steps_d   = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    step_next = step_idx_q + 1'b1;
    half_n    = in_data_i.step_count >> 1;
    ramp_new  = (ramp_steps_q < half_n) ? ramp_steps_q : half_n;
    start_cd  = clamp_delay((ramp_new == '0) ? steady_delay_q : start_delay_q);
    ht_dec    = (half_timer_q != '0) ? half_timer_q - 1'b1 : half_timer_q;
    accel     = step_idx_q < ramp_q;
    decel     = step_idx_q > (total_q - ramp_q);
    decel_m   = {1'b0, step_idx_q} + {1'b0, ramp_steps_q} - {1'b0, total_q};
    st_gt_sd  = start_delay_q > steady_delay_q;
    diff_mag  = st_gt_sd ? start_delay_q - steady_delay_q : steady_delay_q - start_delay_q;
    calc_sum  = neg_q ? {1'b0, base_q} - {1'b0, md_rsp.quot}
                      : {1'b0, base_q} + {1'b0, md_rsp.quot};
    calc_cd   = clamp_delay(calc_sum[CFG_W-1:0]);
  end

  always_comb begin
    state_d      = state_q;
    step_idx_d   = step_idx_q;
    total_d      = total_q;
    ramp_d       = ramp_q;
    cur_delay_d  = cur_delay_q;
    half_timer_d = half_timer_q;
    phase_d      = phase_q;
    moving_d     = moving_q;
    dir_d        = dir_q;
    done_d       = done_q;
    base_d       = base_q;
    neg_d        = neg_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    md_req       = '0;
    fin          = 1'b0;
    fin_delay    = cur_delay_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          done_d  = 1'b0;
          state_d = ST_OUT;
          if (in_data_i.mode == MODE_START) begin
            if (!moving_q) begin
              dir_d = in_data_i.direction;
              if (in_data_i.step_count != '0) begin
                total_d      = in_data_i.step_count;
                ramp_d       = ramp_new;
                cur_delay_d  = start_cd;
                half_timer_d = start_cd;
                step_idx_d   = '0;
                phase_d      = 1'b1;
                moving_d     = 1'b1;
              end
            end
          end else if (moving_q) begin
            half_timer_d = ht_dec;
            if (ht_dec == '0) begin
              if (phase_q) begin
                phase_d      = 1'b0;
                half_timer_d = cur_delay_q;
              end else if ((ramp_steps_q != '0) && (accel || decel)) begin
                md_req.start   = 1'b1;
                md_req.mult    = accel ? step_idx_q : decel_m[CFG_W-1:0];
                md_req.mcand   = diff_mag;
                md_req.divisor = ramp_steps_q;
                base_d         = accel ? start_delay_q : steady_delay_q;
                neg_d          = accel ? st_gt_sd : (steady_delay_q > start_delay_q);
                state_d        = ST_CALC;
              end else begin
                fin = 1'b1;
              end
            end
          end
        end
      end
      ST_CALC: begin
        if (md_rsp.done) begin
          cur_delay_d = calc_cd;
          fin_delay   = calc_cd;
          fin         = 1'b1;
          state_d     = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.pulse         = moving_q & phase_q;
          out_d.dir_line      = dir_q;
          out_d.driver_enable = moving_q;
          out_d.busy_res      = moving_q;
          out_d.done_res      = done_q;
          out_valid_d         = 1'b1;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // end of the low half: advance the step, finish or start the next one
    if (fin) begin
      step_idx_d = step_next;
      if ((step_next >= total_q) || (step_next == '0)) begin
        moving_d     = 1'b0;
        done_d       = 1'b1;
        half_timer_d = '0;
      end else begin
        phase_d      = 1'b1;
        half_timer_d = fin_delay;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      start_delay_q  <= START_DELAY_RST;
      steady_delay_q <= STEADY_DELAY_RST;
      ramp_steps_q   <= RAMP_STEPS_RST;
      step_idx_q     <= '0;
      total_q        <= '0;
      ramp_q         <= '0;
      cur_delay_q    <= '0;
      half_timer_q   <= '0;
      phase_q        <= 1'b0;
      moving_q       <= 1'b0;
      dir_q          <= 1'b0;
      done_q         <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      start_delay_q  <= start_delay_d;
      steady_delay_q <= steady_delay_d;
      ramp_steps_q   <= ramp_steps_d;
      step_idx_q     <= step_idx_d;
      total_q        <= total_d;
      ramp_q         <= ramp_d;
      cur_delay_q    <= cur_delay_d;
      half_timer_q   <= half_timer_d;
      phase_q        <= phase_d;
      moving_q       <= moving_d;
      dir_q          <= dir_d;
      done_q         <= done_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    neg_q  <= neg_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  a_calc_only_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC) |-> moving_q)
    else $error("delay computation running without a move");

  a_md_done_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_rsp.done |-> (state_q == ST_CALC))
    else $error("divider result outside of computation state");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.done_res) |-> (!out_data_o.busy_res && !out_data_o.pulse))
    else $error("done beat still shows busy or pulse");

  a_accept_then_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second beat taken before result of first");

endmodule

`default_nettype wire
